FILE: rtl/core/ppt_pkg.sv
// Package: widths, register indexes, reset rows, lane helpers
`timescale 1ns / 1ps
package ppt_pkg;
   localparam int CoordWidth = 32;
   localparam int RowWidth   = 64;
   localparam int CoefWidth  = 16;
   localparam int SumWidth   = 50;
   localparam int AbsWidth   = 49;
   // dividend is |numerator| scaled by 2^16 for a Q16.16 quotient
   localparam int NumWidth   = AbsWidth + 16;
   // quotient magnitude bits kept before saturation check (2^32 covers the limit)
   localparam int QuotWidth  = 33;
   localparam int IndexWidth = 2;

   typedef enum logic [IndexWidth-1:0] {
      REG_ROW_X = 2'd0,
      REG_ROW_Y = 2'd1,
      REG_ROW_Z = 2'd2,
      REG_ROW_W = 2'd3
   } reg_index_type;

   localparam logic [RowWidth-1:0] RowXReset = 64'h0000_0000_0000_1000;
   localparam logic [RowWidth-1:0] RowYReset = 64'h0000_0000_1000_0000;
   localparam logic [RowWidth-1:0] RowZReset = 64'h0000_1000_0000_0000;
   localparam logic [RowWidth-1:0] RowWReset = 64'h1000_0000_0000_0000;

   localparam logic [CoordWidth-1:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [CoordWidth-1:0] NegLimit = 32'h8000_0000;

   // one lane of the divide data passed from cell to cell
   typedef struct packed {
      logic [NumWidth-1:0]  rem;
      logic [QuotWidth-1:0] quo;
      logic                 neg;
      logic                 big;
   } lane_type;

   typedef struct packed {
      logic                valid;
      lane_type [2:0]      lanes;
      logic [AbsWidth-1:0] den;
      logic                zero;
   } cell_data_type;
endpackage

FILE: rtl/core/ppt_if.sv
// Valid/ready channel interfaces for requests, responses and register writes
`timescale 1ns / 1ps
interface ppt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_x;
   logic [31:0] in_y;
   logic [31:0] in_z;
   modport source (output valid, in_x, in_y, in_z, input ready);
   modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface ppt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic        zero_divisor;
   logic        clipped;
   modport source (output valid, out_x, out_y, out_z, zero_divisor, clipped, input ready);
   modport sink (input valid, out_x, out_y, out_z, zero_divisor, clipped, output ready);
endinterface

interface ppt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/projective_point_transform_unit.sv
// Top level: register file, dot-product front end, divider cell chain, output stage
`timescale 1ns / 1ps
// The pipeline holds 2 dot-product stages, 33 cells of the one-bit-per-cell divider
//   chain and 1 output register.
// Throughput: one point per cycle; the pipeline stalls only when the output is held.
// Reset: synchronous, active high; clears valids and loads the identity transform.
module projective_point_transform_unit (
   input  logic         clock,
   input  logic         reset,
   ppt_req_if.sink      req,
   ppt_rsp_if.source    rsp,
   ppt_csr_if.sink      csr
);
   import ppt_pkg::*;

   localparam int QuotBits = QuotWidth;

   logic [RowWidth-1:0] row_x_ff, row_y_ff, row_z_ff, row_w_ff;
   cell_data_type       chain [QuotBits+1];
   logic                advance;
   logic                out_v_ff;
   logic [CoordWidth-1:0] ox_ff, oy_ff, oz_ff;
   logic                zd_ff, cl_ff;
   logic [CoordWidth-1:0] res_c [3];
   logic [2:0]          clip_c;
   cell_data_type       last;

   assign csr.ready = 1'b1;
   assign advance   = !out_v_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= RowXReset;
         row_y_ff <= RowYReset;
         row_z_ff <= RowZReset;
         row_w_ff <= RowWReset;
      end else if (csr.valid) begin
         case (reg_index_type'(csr.index))
            REG_ROW_X: row_x_ff <= csr.data;
            REG_ROW_Y: row_y_ff <= csr.data;
            REG_ROW_Z: row_z_ff <= csr.data;
            REG_ROW_W: row_w_ff <= csr.data;
            default: ;
         endcase
      end
   end

   ppt_dot u_dot (
      .clock, .reset, .advance,
      .in_valid(req.valid),
      .in_x(req.in_x), .in_y(req.in_y), .in_z(req.in_z),
      .row_x(row_x_ff), .row_y(row_y_ff), .row_z(row_z_ff), .row_w(row_w_ff),
      .out_data(chain[0])
   );

   // MSB first: cell i produces quotient bit QuotBits-1-i
   for (genvar i = 0; i < QuotBits; i++) begin : g_cell
      ppt_cell #(.Shift(QuotBits-1-i)) u_cell (
         .clock, .reset, .advance,
         .in_data(chain[i]), .out_data(chain[i+1])
      );
   end

   assign last = chain[QuotBits];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic [QuotWidth-1:0] mag;
         logic [QuotWidth-1:0] lim;
         mag = QuotWidth'(last.lanes[l].quo);
         lim = last.lanes[l].neg ? QuotWidth'(NegLimit) : QuotWidth'(PosLimit);
         clip_c[l] = last.lanes[l].big || (mag > lim);
         if (clip_c[l]) mag = lim;
         res_c[l] = last.lanes[l].neg ? CoordWidth'(-mag) : CoordWidth'(mag);
         if (last.zero) res_c[l] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= last.valid;
      if (advance) begin
         ox_ff <= res_c[0];
         oy_ff <= res_c[1];
         oz_ff <= res_c[2];
         zd_ff <= last.zero;
         cl_ff <= !last.zero && (|clip_c);
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.out_x        = ox_ff;
   assign rsp.out_y        = oy_ff;
   assign rsp.out_z        = oz_ff;
   assign rsp.zero_divisor = zd_ff;
   assign rsp.clipped      = cl_ff;
endmodule

FILE: rtl/core/ppt_dot.sv
// Front end: four dot products in two registered stages, then sign/magnitude split
`timescale 1ns / 1ps
module ppt_dot (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [ppt_pkg::CoordWidth-1:0] in_x,
   input  logic [ppt_pkg::CoordWidth-1:0] in_y,
   input  logic [ppt_pkg::CoordWidth-1:0] in_z,
   input  logic [ppt_pkg::RowWidth-1:0]   row_x,
   input  logic [ppt_pkg::RowWidth-1:0]   row_y,
   input  logic [ppt_pkg::RowWidth-1:0]   row_z,
   input  logic [ppt_pkg::RowWidth-1:0]   row_w,
   output ppt_pkg::cell_data_type         out_data
);
   import ppt_pkg::*;

   typedef logic signed [SumWidth-1:0] prod_type;

   logic                      v1_ff, v1_in, v2_ff, v2_in;
   prod_type [3:0][3:0]       prod_ff, prod_in;
   prod_type [3:0]            sum_ff, sum_in;
   logic [RowWidth-1:0]       rows [4];
   logic [AbsWidth-1:0]       abs_c [3];
   cell_data_type             data_c;

   assign rows[0] = row_x;
   assign rows[1] = row_y;
   assign rows[2] = row_z;
   assign rows[3] = row_w;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_in[r][0] = prod_type'($signed(rows[r][15:0]) * $signed(in_x));
         prod_in[r][1] = prod_type'($signed(rows[r][31:16]) * $signed(in_y));
         prod_in[r][2] = prod_type'($signed(rows[r][47:32]) * $signed(in_z));
         prod_in[r][3] = prod_type'({{(SumWidth-32){rows[r][63]}}, rows[r][63:48], 16'h0});
         sum_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + prod_ff[r][3];
      end
      v1_in = in_valid;
      v2_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   // big: quotient needs more than QuotWidth bits, i.e. |num| >= |den| << 17
   always_comb begin
      data_c.valid = v2_ff;
      data_c.den   = AbsWidth'(sum_ff[3][SumWidth-1] ? -sum_ff[3] : sum_ff[3]);
      data_c.zero  = (sum_ff[3] == '0);
      for (int l = 0; l < 3; l++) begin
         abs_c[l] = AbsWidth'(sum_ff[l][SumWidth-1] ? -sum_ff[l] : sum_ff[l]);
         data_c.lanes[l].rem = {abs_c[l], 16'h0};
         data_c.lanes[l].quo = '0;
         data_c.lanes[l].neg = sum_ff[l][SumWidth-1] ^ sum_ff[3][SumWidth-1];
         data_c.lanes[l].big = ({17'h0, abs_c[l]} >= {data_c.den, 17'h0});
      end
   end
   assign out_data = data_c;
endmodule

FILE: rtl/core/ppt_cell.sv
// One restoring-division cell: one quotient bit for each of three lanes
`timescale 1ns / 1ps
module ppt_cell #(
   parameter int Shift = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ppt_pkg::cell_data_type in_data,
   output ppt_pkg::cell_data_type out_data
);
   import ppt_pkg::*;

   cell_data_type data_ff, data_in;
   logic [AbsWidth+QuotWidth:0] trial [3];
   logic [AbsWidth+QuotWidth:0] dsh;

   // compare rem against den << Shift, no wide shifter at runtime
   always_comb begin
      data_in = in_data;
      dsh = (AbsWidth+QuotWidth+1)'(in_data.den) << Shift;
      for (int l = 0; l < 3; l++) begin
         trial[l] = (AbsWidth+QuotWidth+1)'(in_data.lanes[l].rem);
         if (trial[l] >= dsh) begin
            data_in.lanes[l].rem = NumWidth'(trial[l] - dsh);
            data_in.lanes[l].quo[Shift] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) data_ff.valid <= 1'b0;
      else if (advance) data_ff.valid <= data_in.valid;
      if (advance) begin
         data_ff.lanes <= data_in.lanes;
         data_ff.den   <= data_in.den;
         data_ff.zero  <= data_in.zero;
      end
   end
   assign out_data = data_ff;
endmodule

FILE: rtl/core/ppt_checker.sv
// Port-level checker for the transform unit, bound to the top level
`timescale 1ns / 1ps
module ppt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x,
   input logic        rsp_zero_divisor,
   input logic        rsp_clipped
);
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |-> rsp_out_x == 32'h0 && !rsp_clipped)
      else $error("zero divisor with nonzero output");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output held");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("response dropped under stall");
endmodule

bind projective_point_transform_unit ppt_checker u_ppt_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_out_x(rsp.out_x),
   .rsp_zero_divisor(rsp.zero_divisor), .rsp_clipped(rsp.clipped)
);
